@@ hdl/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int SlotsDef    = 16;
  localparam int PageBitsDef = 16;
  localparam int CapW        = 5;
  localparam int FaultW      = 32;

  localparam logic [CapW-1:0]   CapReset = CapW'(16);
  localparam logic [FaultW-1:0] FaultMax = '1;

  // Per-transaction control broadcast from the top level to every cell
  typedef struct packed {
    logic capture;  // latch the compare result for a new reference
    logic commit;   // apply the update for the reference in flight
    logic hit;      // reference was resident
    logic evict;    // miss with all slots in use
    logic append;   // miss with a free slot
  } cell_ctrl_t;

endpackage

@@ hdl/lru_cell.sv @@
// ----------------------------------------------------------------------------
// lru_cell
// One slot of the recency chain: holds a page, compares it against a new
// reference, and takes its upper neighbor's page when the chain shifts.
// ----------------------------------------------------------------------------
module lru_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = lru_pkg::PageBitsDef,
  parameter int OCC_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lru_pkg::cell_ctrl_t  ctrl_i,
  input  logic [OCC_W-1:0]     occ_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [PAGE_BITS-1:0] next_page_i,
  input  logic                 seen_i,
  output logic                 seen_o,
  output logic [PAGE_BITS-1:0] page_o
);

  localparam logic [OCC_W-1:0] IdxV  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] IdxV1 = OCC_W'(IDX + 1);

  logic [PAGE_BITS-1:0] slot_q, slot_d;
  logic                 match_q;
  logic                 active, last, tail, shift, take_new;

  assign active = IdxV < occ_i;
  assign last   = IdxV1 == occ_i;
  assign tail   = IdxV == occ_i;

  // Ripple the "match at or below this slot" flag upward
  assign seen_o = seen_i | (match_q & active);

  assign shift = ctrl_i.commit & active & ~last &
                 ((ctrl_i.hit & seen_o) | ctrl_i.evict);
  assign take_new = ctrl_i.commit &
                    (((ctrl_i.hit | ctrl_i.evict) & last) | (ctrl_i.append & tail));

  always_comb begin
    slot_d = slot_q;
    if (shift) begin
      slot_d = next_page_i;
    end else if (take_new) begin
      slot_d = page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= (slot_q == page_i);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign page_o = slot_q;

endmodule

@@ hdl/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement built as a chain of slot cells.
// ----------------------------------------------------------------------------
// For each reference, on the accepting edge every slot
// compares its page against page_i and registers the result; in the next
// cycle (busy high) the hit chain resolves, the result is shown for that one
// cycle with result_valid_o, and the slots shift at its closing edge. The
// receiver cannot stall: the result is gone after its strobe cycle. Slot 0
// holds the least recent page. capacity is taken from cfg_wdata_i when
// cfg_we_i is high; zero acts as one and values above SLOTS act as SLOTS.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int SLOTS     = lru_pkg::SlotsDef,
  parameter int PAGE_BITS = lru_pkg::PageBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lru_pkg::CapW-1:0]   cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [PAGE_BITS-1:0]       page_i,
  output logic                       result_valid_o,
  output logic                       hit_o,
  output logic                       evict_valid_o,
  output logic [PAGE_BITS-1:0]       evicted_page_o,
  output logic [lru_pkg::FaultW-1:0] fault_count_o
);

  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (OCC_W > lru_pkg::CapW) ? OCC_W : lru_pkg::CapW;
  localparam logic [OCC_W-1:0] SlotsV = OCC_W'(SLOTS);

  logic [lru_pkg::CapW-1:0]   cap_q;
  logic [lru_pkg::CapW-1:0]   cap_eff;
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic [lru_pkg::FaultW-1:0] fault_q, fault_d;
  logic                       phase_q;
  logic [PAGE_BITS-1:0]       page_q;
  logic                       accept, hit, full, evict, append;
  lru_pkg::cell_ctrl_t        ctrl;

  logic [SLOTS:0]             seen;
  logic [PAGE_BITS-1:0]       slot_page [SLOTS+1];

  assign accept = start & ~phase_q;
  assign busy   = phase_q;

  assign hit     = seen[SLOTS];
  assign cap_eff = (cap_q == '0) ? lru_pkg::CapW'(1) : cap_q;
  assign full    = (CMP_W'(occ_q) >= CMP_W'(cap_eff)) || (occ_q == SlotsV);
  assign evict   = ~hit & full;
  assign append  = ~hit & ~full;

  always_comb begin
    ctrl         = '0;
    ctrl.capture = accept;
    ctrl.commit  = phase_q;
    ctrl.hit     = hit;
    ctrl.evict   = evict;
    ctrl.append  = append;
  end

  assign seen[0]          = 1'b0;
  assign slot_page[SLOTS] = '0;

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    lru_cell #(
      .IDX       (j),
      .PAGE_BITS (PAGE_BITS),
      .OCC_W     (OCC_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (occ_q),
      .page_i      (phase_q ? page_q : page_i),
      .next_page_i (slot_page[j+1]),
      .seen_i      (seen[j]),
      .seen_o      (seen[j+1]),
      .page_o      (slot_page[j])
    );
  end

  always_comb begin
    occ_d   = occ_q;
    fault_d = fault_q;
    if (phase_q) begin
      if (append) begin
        occ_d = occ_q + OCC_W'(1);
      end
      if (!hit && fault_q != lru_pkg::FaultMax) begin
        fault_d = fault_q + lru_pkg::FaultW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= lru_pkg::CapReset;
      occ_q   <= '0;
      fault_q <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      occ_q   <= occ_d;
      fault_q <= fault_d;
      phase_q <= accept;
    end
  end

  // Hold the reference for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_i;
    end
  end

  assign result_valid_o = phase_q;
  assign hit_o          = hit;
  assign evict_valid_o  = evict;
  assign evicted_page_o = evict ? slot_page[0] : '0;
  assign fault_count_o  = fault_d;

endmodule

@@ hdl/lru_chk.sv @@
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for the LRU page replacement block.
// ----------------------------------------------------------------------------
module lru_chk #(
  parameter int PAGE_BITS = lru_pkg::PageBitsDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input logic                       hit_o,
  input logic                       evict_valid_o,
  input logic [PAGE_BITS-1:0]       evicted_page_o,
  input logic [lru_pkg::FaultW-1:0] fault_count_o
);

  // Every accepted transaction yields its result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_valid_o)
    else $error("accepted reference produced no result");

  // Results come only while busy, and never twice in a row
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy ##1 !result_valid_o)
    else $error("result strobe outside a single busy cycle");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && hit_o |-> !evict_valid_o)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !evict_valid_o |-> evicted_page_o == '0)
    else $error("evicted page nonzero without eviction");

  // Fault total advances by one on a miss unless saturated; this property checks only that hits leave it
  a_fault_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o ##2 result_valid_o && hit_o |->
      fault_count_o == $past(fault_count_o, 2))
    else $error("fault total changed on a hit");

endmodule

bind lru_page_replacement lru_chk #(
  .PAGE_BITS (PAGE_BITS)
) u_lru_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .hit_o          (hit_o),
  .evict_valid_o  (evict_valid_o),
  .evicted_page_o (evicted_page_o),
  .fault_count_o  (fault_count_o)
);

@@ verif/lru_page_replacement_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_checker
// Watches the reference and result channels of lru_page_replacement, keeps a
// shadow recency stack to predict every result, and compares field by field.
// ----------------------------------------------------------------------------
module lru_page_replacement_checker #(
  parameter int SLOTS     = lru_pkg::SlotsDef,
  parameter int PAGE_BITS = lru_pkg::PageBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lru_pkg::CapW-1:0]   cfg_wdata_i,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [PAGE_BITS-1:0]       page_i,
  input  logic                       result_valid_i,
  input  logic                       hit_i,
  input  logic                       evict_valid_i,
  input  logic [PAGE_BITS-1:0]       evicted_page_i,
  input  logic [lru_pkg::FaultW-1:0] fault_count_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  import lru_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic                 evict;
    logic [PAGE_BITS-1:0] victim;
    logic [FaultW-1:0]    faults;
  } lru_result_t;

  logic [PAGE_BITS-1:0] stack_q [SLOTS];
  int unsigned          occupancy_q;
  logic [FaultW-1:0]    faults_q;
  logic [CapW-1:0]      capacity_q;
  lru_result_t          expected_results [$];
  int                   fails = 0;

  // Apply one reference to the shadow stack; slot 0 is the least recent page
  task automatic reference_page(input logic [PAGE_BITS-1:0] pg, output lru_result_t res);
    int unsigned limit;
    int unsigned pos;
    int unsigned j;
    limit = (capacity_q == '0) ? 1 :
            ((int'(capacity_q) > SLOTS) ? SLOTS : int'(capacity_q));
    pos = occupancy_q;
    res = '0;
    for (j = 0; j < occupancy_q; j++) begin
      if (pos == occupancy_q && stack_q[j] == pg) pos = j;
    end
    if (pos < occupancy_q) begin
      res.hit = 1'b1;
      for (j = pos; j + 1 < occupancy_q; j++) stack_q[j] = stack_q[j + 1];
      stack_q[occupancy_q - 1] = pg;
    end else begin
      if (faults_q != FaultMax) faults_q++;
      if (occupancy_q >= limit) begin
        // full (or capacity lowered below occupancy): drop the LRU, keep size
        res.evict  = 1'b1;
        res.victim = stack_q[0];
        for (j = 0; j + 1 < occupancy_q; j++) stack_q[j] = stack_q[j + 1];
        stack_q[occupancy_q - 1] = pg;
      end else begin
        stack_q[occupancy_q] = pg;
        occupancy_q++;
      end
    end
    res.faults = faults_q;
  endtask

  task automatic check_field(input string field, input logic [FaultW-1:0] want,
                             input logic [FaultW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lru_result_t want;
    if (!rst_ni) begin
      occupancy_q = 0;
      faults_q    = '0;
      capacity_q  = CapReset;
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      // retire the older transaction first
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: hit %0b evict %0b page 0x%0h faults %0d",
                   $time, hit_i, evict_valid_i, evicted_page_i, fault_count_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", FaultW'(want.hit), FaultW'(hit_i));
          check_field("evict_valid", FaultW'(want.evict), FaultW'(evict_valid_i));
          check_field("evicted_page", FaultW'(want.victim), FaultW'(evicted_page_i));
          check_field("fault_count", want.faults, fault_count_i);
        end
      end
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (start_i && !busy_i) begin
        reference_page(page_i, want);
        expected_results.push_back(want);
      end
      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ verif/tb_lru_page_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Drives page references in random bursts over a series of capacity settings
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  import lru_pkg::*;

  localparam int SLOTS       = SlotsDef;
  localparam int PAGE_BITS   = PageBitsDef;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REFS  = 125;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CapW-1:0]      cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [PAGE_BITS-1:0] page;
  logic                 result_valid;
  logic                 hit;
  logic                 evict_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FaultW-1:0]    fault_count;
  int                   pending;
  int                   fail_count;

  lru_page_replacement #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .page_i         (page),
    .result_valid_o (result_valid),
    .hit_o          (hit),
    .evict_valid_o  (evict_valid),
    .evicted_page_o (evicted_page),
    .fault_count_o  (fault_count)
  );

  lru_page_replacement_checker #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_i         (busy),
    .page_i         (page),
    .result_valid_i (result_valid),
    .hit_i          (hit),
    .evict_valid_i  (evict_valid),
    .evicted_page_i (evicted_page),
    .fault_count_i  (fault_count),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lru_page_replacement verification failed");
    $finish;
  end

  task automatic write_capacity(input logic [CapW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold start until the transaction is taken
  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    start <= 1'b1;
    page  <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CapW-1:0] cap, input int count);
    int                   sent;
    int                   burst;
    int                   gap;
    int                   limit;
    int                   span;
    logic [PAGE_BITS-1:0] base;
    logic [PAGE_BITS-1:0] pg;
    write_capacity(cap);
    limit = (cap == '0) ? 1 : ((int'(cap) > SLOTS) ? SLOTS : int'(cap));
    base  = PAGE_BITS'($urandom);
    span  = limit + $urandom_range(0, limit);
    sent  = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        base = PAGE_BITS'($urandom);
        span = limit + $urandom_range(0, limit);
      end
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        // mostly a working set near capacity, some fully random pages
        if ($urandom_range(0, 9) == 0) pg = PAGE_BITS'($urandom);
        else pg = base + PAGE_BITS'($urandom_range(0, span));
        send_page(pg);
        sent++;
      end
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [10];
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd20, 5'd5, 5'd12, 5'd3};
    rst_n     = 1'b0;
    start     <= 1'b0;
    page      <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill, hit at LRU, evict, hit at MRU and at LRU, then evict
    write_capacity(5'd3);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'h0000);
    send_page(16'hAAAA);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'hFFFF);
    send_page(16'h0001);
    send_page(16'h8000);
    drain();

    // capacity lowered below occupancy: misses evict but the stack keeps size
    write_capacity(5'd1);
    send_page(16'h1234);
    send_page(16'h1234);
    send_page(16'h8000);
    send_page(16'h4321);
    send_page(16'h4321);
    drain();

    // zero capacity acts as one
    write_capacity(5'd0);
    send_page(16'h7FFF);
    send_page(16'h7FFF);
    send_page(16'hFFFE);
    send_page(16'h7FFF);
    drain();

    foreach (phase_caps[i]) run_phase(phase_caps[i], PHASE_REFS);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lru_pkg.sv
hdl/lru_cell.sv
hdl/lru_page_replacement.sv
hdl/lru_chk.sv
verif/lru_page_replacement_checker.sv
verif/tb_lru_page_replacement.sv
